// ----- rtl/core/brick_pattern_shader_macros.svh -----
// Assertion shorthands used by the checker of the brick shader.
`ifndef BRICK_PATTERN_SHADER_MACROS_SVH
`define BRICK_PATTERN_SHADER_MACROS_SVH

// Concurrent assertion on a clock, disabled while reset is low.
`define BPS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Trigger in one cycle implies a condition in the next.
`define BPS_ASSERT_NEXT(lbl, clk, rstn, trig, nxt, msg) \
  `BPS_ASSERT(lbl, clk, rstn, (trig) |=> (nxt), msg)

`endif

// ----- rtl/core/bps_pkg.sv -----
`default_nettype none
package bps_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int CFG_W         = 31;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int IN_TDATA_W    = 96;
  localparam int OUT_TDATA_W   = 72;
  localparam int VALUE_W       = 17;
  localparam int GRAD_W        = 18;

  localparam logic [CFG_W-1:0] BRICK_WIDTH_RST  = 31'd65536;
  localparam logic [CFG_W-1:0] BRICK_HEIGHT_RST = 31'd32768;
  localparam logic [CFG_W-1:0] MORTAR_RST       = 31'd3277;

  localparam logic [VALUE_W-1:0] Q16_ONE = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRICK_WIDTH  = 2'd0,
    REG_BRICK_HEIGHT = 2'd1,
    REG_MORTAR       = 2'd2
  } bps_reg_e;

  typedef enum logic [1:0] {
    CFG_SUM,
    CFG_DIV,
    CFG_IDLE
  } bps_cfg_state_e;

  // Derived configuration handed to the datapath.
  typedef struct packed {
    logic [COORD_W-1:0] tw;
    logic [COORD_W-1:0] th;
    logic               mortar_zero;
  } bps_cfg_t;

endpackage
`default_nettype wire

// ----- rtl/core/bps_pipe.sv -----
`default_nettype none
module bps_pipe #(
  parameter int FRAC_BITS = bps_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                adv_i,
  input  wire logic                                in_valid_i,
  input  wire logic signed [bps_pkg::COORD_W-1:0]  pt_x_i,
  input  wire logic signed [bps_pkg::COORD_W-1:0]  pt_y_i,
  input  wire logic signed [bps_pkg::COORD_W-1:0]  pt_z_i,
  input  wire bps_pkg::bps_cfg_t                   cfg_i,
  input  wire logic [FRAC_BITS-1:0]                mw_i,
  input  wire logic [FRAC_BITS-1:0]                mh_i,
  output logic                                     out_valid_o,
  output logic [bps_pkg::VALUE_W-1:0]              value_o,
  output logic signed [bps_pkg::GRAD_W-1:0]        gx_o,
  output logic signed [bps_pkg::GRAD_W-1:0]        gy_o,
  output logic signed [bps_pkg::GRAD_W-1:0]        gz_o
);

  localparam int F    = FRAC_BITS;
  localparam int PW   = bps_pkg::COORD_W;
  localparam int MODN = PW;
  localparam int LAT  = 45 + 2 * F;
  localparam int SHR  = (F >= 16) ? F - 16 : 0;
  localparam int SHL  = (F >= 16) ? 0 : 16 - F;
  localparam int CW   = F + 17;
  localparam logic [F:0]   ONE   = (F + 1)'(1) << F;
  localparam logic [F+1:0] THREE = (F + 2)'(3) << F;
  localparam logic [F-1:0] HALF  = F'(1) << (F - 1);

  logic [LAT-1:0] vld_q;

  logic signed [PW-1:0] p_q [3];
  logic [PW-1:0] tot [3];
  logic [PW+1:0] dmod [3];
  logic [F-1:0]  den [3];

  logic [PW-1:0] md_mag_q [MODN+1][3];
  logic [PW:0]   md_rem_q [MODN+1][3];
  logic          md_neg_q [MODN+1][3];
  logic [PW+1:0] md_sh    [1:MODN][3];
  logic [PW:0]   md_rem_d [1:MODN][3];

  logic [PW:0]   r2_q [3];
  logic          sp_ge [3];

  logic [PW-1:0] fr_rem_q [F+1][3];
  logic [F-1:0]  fr_q_q   [F+1][3];
  logic          fr_ey_q  [F+1];
  logic [PW:0]   fr_sh    [1:F][3];
  logic          fr_ge    [1:F][3];

  logic [F-1:0]  f_q [3];
  logic          rg_near [3];
  logic          rg_far  [3];
  logic [F-1:0]  rg_n    [3];

  logic [F-1:0]  td_rem_q  [F+1][3];
  logic [F-1:0]  td_t_q    [F+1][3];
  logic          td_near_q [F+1][3];
  logic          td_far_q  [F+1][3];
  logic [F:0]    td_sh     [1:F][3];
  logic          td_ge     [1:F][3];

  logic [2*F-1:0] m1_sq [3];
  logic [2*F:0]   m1_pe [3];
  logic [F-1:0]   m1_t2_q [3];
  logic [F-1:0]   m1_t_q [3];
  logic [F:0]     m1_e_q [3];
  logic           m1_near_q [3];
  logic           m1_far_q [3];

  logic [F+1:0]   m2_k [3];
  logic [2*F+1:0] m2_ps [3];
  logic [F:0]     m2_s_q [3];
  logic [F:0]     m2_e_q [3];
  logic           m2_near_q [3];
  logic           m2_far_q [3];

  logic [F:0]     w_q [3];
  logic [F:0]     slm_q [3];
  logic           sln_q [3];

  logic [2*F+1:0] v1_p;
  logic [F:0]     v1_wxy_q;
  logic [F:0]     v1_wz_q;
  logic [F:0]     v1_slm_q [3];
  logic           v1_sln_q [3];

  logic [2*F+1:0] v2_p;
  logic [F:0]     v2_val_q;
  logic [F:0]     v2_slm_q [3];
  logic           v2_sln_q [3];

  logic [2*F+1:0] g_p [3];
  logic [F:0]     g_m_q [3];
  logic           g_n_q [3];
  logic [F:0]     g_val_q;

  logic [16:0]    o_val_q;
  logic [17:0]    o_g_q [3];
  logic [16:0]    o_val_d;
  logic [17:0]    o_g_d [3];

  function automatic logic [16:0] to_q16(input logic [F:0] m);
    logic [CW-1:0] x;
    x = CW'(m);
    x = (x >> SHR) << SHL;
    if (x > CW'(bps_pkg::Q16_ONE)) begin
      x = CW'(bps_pkg::Q16_ONE);
    end
    return x[16:0];
  endfunction

  always_comb begin
    tot[0] = cfg_i.tw;
    tot[1] = cfg_i.th;
    tot[2] = cfg_i.tw;
    den[0] = mw_i;
    den[1] = mh_i;
    den[2] = mw_i;
    for (int a = 0; a < 3; a++) begin
      dmod[a] = {1'b0, tot[a], 1'b0};
    end
  end

  // Valid bits move in lockstep with the payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // Floor remainder modulo twice the period, one bit per stage.
  always_comb begin
    for (int j = 1; j <= MODN; j++) begin
      for (int a = 0; a < 3; a++) begin
        md_sh[j][a] = {md_rem_q[j-1][a], md_mag_q[j-1][a][PW-1]};
        if (md_sh[j][a] >= dmod[a]) begin
          md_rem_d[j][a] = (PW + 1)'(md_sh[j][a] - dmod[a]);
        end else begin
          md_rem_d[j][a] = md_sh[j][a][PW:0];
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sp_ge[a] = r2_q[a] >= {1'b0, tot[a]};
    end
  end

  // Fraction of the period, one quotient bit per stage.
  always_comb begin
    for (int j = 1; j <= F; j++) begin
      for (int a = 0; a < 3; a++) begin
        fr_sh[j][a] = {fr_rem_q[j-1][a], 1'b0};
        fr_ge[j][a] = fr_sh[j][a] >= {1'b0, tot[a]};
      end
    end
  end

  // Edge regions: near edge below the mortar width, far edge above one minus it.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rg_near[a] = f_q[a] < den[a];
      rg_far[a]  = {1'b0, f_q[a]} >= (ONE - {1'b0, den[a]});
      if (rg_near[a]) begin
        rg_n[a] = f_q[a];
      end else begin
        rg_n[a] = F'({1'b0, f_q[a]} + {1'b0, den[a]} - ONE);
      end
    end
  end

  // Edge parameter t, one quotient bit per stage.
  always_comb begin
    for (int j = 1; j <= F; j++) begin
      for (int a = 0; a < 3; a++) begin
        td_sh[j][a] = {td_rem_q[j-1][a], 1'b0};
        td_ge[j][a] = td_sh[j][a] >= {1'b0, den[a]};
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      m1_sq[a] = (2 * F)'(td_t_q[F][a]) * (2 * F)'(td_t_q[F][a]);
      m1_pe[a] = (2 * F + 1)'(td_t_q[F][a]) * (2 * F + 1)'(ONE - {1'b0, td_t_q[F][a]});
      m2_k[a]  = THREE - (F + 2)'({m1_t_q[a], 1'b0});
      m2_ps[a] = (2 * F + 2)'(m1_t2_q[a]) * (2 * F + 2)'(m2_k[a]);
      g_p[a]   = (2 * F + 2)'(v2_slm_q[a]) * (2 * F + 2)'(v2_val_q);
    end
    v1_p = (2 * F + 2)'(w_q[0]) * (2 * F + 2)'(w_q[1]);
    v2_p = (2 * F + 2)'(v1_wxy_q) * (2 * F + 2)'(v1_wz_q);
  end

  always_comb begin
    logic [17:0] m;
    m = '0;
    o_val_d = to_q16(g_val_q);
    for (int a = 0; a < 3; a++) begin
      m = {1'b0, to_q16(g_m_q[a])};
      o_g_d[a] = g_n_q[a] ? 18'(~m + 18'd1) : m;
    end
    if (cfg_i.mortar_zero) begin
      o_val_d = bps_pkg::Q16_ONE;
      for (int a = 0; a < 3; a++) begin
        o_g_d[a] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_q[0] <= pt_x_i;
      p_q[1] <= pt_y_i;
      p_q[2] <= pt_z_i;

      for (int a = 0; a < 3; a++) begin
        md_neg_q[0][a] <= p_q[a][PW-1];
        md_mag_q[0][a] <= p_q[a][PW-1] ? PW'(~p_q[a] + 32'd1) : PW'(p_q[a]);
        md_rem_q[0][a] <= '0;
      end
      for (int j = 1; j <= MODN; j++) begin
        for (int a = 0; a < 3; a++) begin
          md_rem_q[j][a] <= md_rem_d[j][a];
          md_mag_q[j][a] <= {md_mag_q[j-1][a][PW-2:0], 1'b0};
          md_neg_q[j][a] <= md_neg_q[j-1][a];
        end
      end

      for (int a = 0; a < 3; a++) begin
        if (md_neg_q[MODN][a] && md_rem_q[MODN][a] != '0) begin
          r2_q[a] <= (PW + 1)'(dmod[a] - (PW + 2)'(md_rem_q[MODN][a]));
        end else begin
          r2_q[a] <= md_rem_q[MODN][a];
        end
      end

      for (int a = 0; a < 3; a++) begin
        fr_rem_q[0][a] <= sp_ge[a] ? PW'(r2_q[a] - {1'b0, tot[a]}) : r2_q[a][PW-1:0];
        fr_q_q[0][a]   <= '0;
      end
      fr_ey_q[0] <= !sp_ge[1];
      for (int j = 1; j <= F; j++) begin
        for (int a = 0; a < 3; a++) begin
          fr_rem_q[j][a] <= fr_ge[j][a] ? PW'(fr_sh[j][a] - {1'b0, tot[a]})
                                        : fr_sh[j][a][PW-1:0];
          fr_q_q[j][a]   <= {fr_q_q[j-1][a][F-2:0], fr_ge[j][a]};
        end
        fr_ey_q[j] <= fr_ey_q[j-1];
      end

      // Shift x and z by half a brick on even courses.
      for (int a = 0; a < 3; a++) begin
        if (a != 1 && fr_ey_q[F]) begin
          f_q[a] <= fr_q_q[F][a] + HALF;
        end else begin
          f_q[a] <= fr_q_q[F][a];
        end
      end

      for (int a = 0; a < 3; a++) begin
        td_rem_q[0][a]  <= rg_n[a];
        td_t_q[0][a]    <= '0;
        td_near_q[0][a] <= rg_near[a];
        td_far_q[0][a]  <= rg_far[a];
      end
      for (int j = 1; j <= F; j++) begin
        for (int a = 0; a < 3; a++) begin
          td_rem_q[j][a]  <= td_ge[j][a] ? F'(td_sh[j][a] - {1'b0, den[a]})
                                         : td_sh[j][a][F-1:0];
          td_t_q[j][a]    <= {td_t_q[j-1][a][F-2:0], td_ge[j][a]};
          td_near_q[j][a] <= td_near_q[j-1][a];
          td_far_q[j][a]  <= td_far_q[j-1][a];
        end
      end

      for (int a = 0; a < 3; a++) begin
        m1_t2_q[a]   <= m1_sq[a][2*F-1:F];
        m1_t_q[a]    <= td_t_q[F][a];
        m1_e_q[a]    <= (F + 1)'(m1_pe[a] >> (F - 2));
        m1_near_q[a] <= td_near_q[F][a];
        m1_far_q[a]  <= td_far_q[F][a];

        m2_s_q[a]    <= (F + 1)'(m2_ps[a] >> F);
        m2_e_q[a]    <= m1_e_q[a];
        m2_near_q[a] <= m1_near_q[a];
        m2_far_q[a]  <= m1_far_q[a];

        if (m2_near_q[a]) begin
          w_q[a] <= m2_s_q[a];
        end else if (m2_far_q[a]) begin
          w_q[a] <= ONE - m2_s_q[a];
        end else begin
          w_q[a] <= ONE;
        end
        slm_q[a] <= (m2_near_q[a] || m2_far_q[a]) ? m2_e_q[a] : '0;
        sln_q[a] <= m2_near_q[a];

        v1_slm_q[a] <= slm_q[a];
        v1_sln_q[a] <= sln_q[a];
        v2_slm_q[a] <= v1_slm_q[a];
        v2_sln_q[a] <= v1_sln_q[a];

        g_m_q[a] <= (F + 1)'(g_p[a] >> F);
        g_n_q[a] <= v2_sln_q[a];

        o_g_q[a] <= o_g_d[a];
      end

      v1_wxy_q <= (F + 1)'(v1_p >> F);
      v1_wz_q  <= w_q[2];
      v2_val_q <= (F + 1)'(v2_p >> F);
      g_val_q  <= v2_val_q;
      o_val_q  <= o_val_d;
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign value_o     = o_val_q;
  assign gx_o        = o_g_q[0];
  assign gy_o        = o_g_q[1];
  assign gz_o        = o_g_q[2];

endmodule
`default_nettype wire

// ----- rtl/core/brick_pattern_shader.sv -----
// Brick pattern shader: takes one 3D point per transfer (signed Q16.16) and
// returns the brick pattern value (unsigned Q1.16, 0 in mortar up to 1.0
// inside a brick) and its three gradient components (signed Q1.16). The
// pipeline takes a new point every cycle unless stalled or recomputing and
// answers each in order; the depth is set by the three chains of
// one-bit-per-stage long division (period remainder, period fraction, edge
// parameter). A stall on the result side holds the whole pipeline. After
// reset and after every register write the mortar fractions are recomputed
// by a serial divider, during which s_axis_tready and cfg_ready_o stay low.
// Registers: index 0 brick width, 1 brick height, 2 mortar thickness, all
// unsigned Q15.16 in the low 31 data bits.
`default_nettype none
module brick_pattern_shader #(
  parameter int FRAC_BITS = bps_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // point_x [31:0], point_y [63:32], point_z [95:64]
  input  wire logic [bps_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // pattern_value [16:0], grad_x [34:17], grad_y [52:35], grad_z [70:53]
  output logic [bps_pkg::OUT_TDATA_W-1:0]            m_axis_tdata,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [bps_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [bps_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int CNT_W = $clog2(FRAC_BITS);
  localparam int PW    = bps_pkg::COORD_W;

  bps_pkg::bps_cfg_state_e state_q, state_d;

  logic [bps_pkg::CFG_W-1:0] bw_q, bh_q, mt_q;
  logic [PW-1:0]             tw_q, th_q;
  logic [PW:0]               dw_rem_q, dh_rem_q;
  logic [PW:0]               dw_sub, dh_sub;
  logic                      dw_ge, dh_ge;
  logic [FRAC_BITS-1:0]      mw_q, mh_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      cfg_fire;
  logic                      cfg_idle;
  logic                      adv;
  logic                      out_valid;
  logic [bps_pkg::VALUE_W-1:0]       value;
  logic signed [bps_pkg::GRAD_W-1:0] gx, gy, gz;
  bps_pkg::bps_cfg_t         cfg;

  // Sequencer for the derived constants.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bps_pkg::CFG_SUM;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cfg_idle = 1'b0;
    case (state_q)
      bps_pkg::CFG_SUM: begin
        state_d = bps_pkg::CFG_DIV;
      end
      bps_pkg::CFG_DIV: begin
        if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
          state_d = bps_pkg::CFG_IDLE;
        end
      end
      bps_pkg::CFG_IDLE: begin
        cfg_idle = 1'b1;
        if (cfg_valid_i) begin
          state_d = bps_pkg::CFG_SUM;
        end
      end
      default: begin
        state_d = bps_pkg::CFG_IDLE;
      end
    endcase
  end

  assign cfg_ready_o = cfg_idle;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Register file; writes to an index past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q <= bps_pkg::BRICK_WIDTH_RST;
      bh_q <= bps_pkg::BRICK_HEIGHT_RST;
      mt_q <= bps_pkg::MORTAR_RST;
    end else if (cfg_fire) begin
      case (bps_pkg::bps_reg_e'(cfg_index_i))
        bps_pkg::REG_BRICK_WIDTH:  bw_q <= cfg_data_i[bps_pkg::CFG_W-1:0];
        bps_pkg::REG_BRICK_HEIGHT: bh_q <= cfg_data_i[bps_pkg::CFG_W-1:0];
        bps_pkg::REG_MORTAR:       mt_q <= cfg_data_i[bps_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Serial restoring division: mortar * 2^(FRAC_BITS-1) / period for both
  // periods at once, one quotient bit per cycle.
  assign dw_ge  = dw_rem_q >= {1'b0, tw_q};
  assign dh_ge  = dh_rem_q >= {1'b0, th_q};
  assign dw_sub = dw_ge ? dw_rem_q - {1'b0, tw_q} : dw_rem_q;
  assign dh_sub = dh_ge ? dh_rem_q - {1'b0, th_q} : dh_rem_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      bps_pkg::CFG_SUM: begin
        tw_q     <= PW'(bw_q) + PW'(mt_q);
        th_q     <= PW'(bh_q) + PW'(mt_q);
        dw_rem_q <= (PW + 1)'(mt_q);
        dh_rem_q <= (PW + 1)'(mt_q);
        cnt_q    <= '0;
      end
      bps_pkg::CFG_DIV: begin
        dw_rem_q <= {dw_sub[PW-1:0], 1'b0};
        dh_rem_q <= {dh_sub[PW-1:0], 1'b0};
        mw_q     <= {mw_q[FRAC_BITS-2:0], dw_ge};
        mh_q     <= {mh_q[FRAC_BITS-2:0], dh_ge};
        cnt_q    <= cnt_q + CNT_W'(1);
      end
      default: ;
    endcase
  end

  assign cfg.tw          = tw_q;
  assign cfg.th          = th_q;
  assign cfg.mortar_zero = (mt_q == '0);

  // Advance the pipeline whenever the output register is free or drained.
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv && cfg_idle;

  bps_pipe #(
    .FRAC_BITS(FRAC_BITS)
  ) u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (s_axis_tvalid && s_axis_tready),
    .pt_x_i     (s_axis_tdata[31:0]),
    .pt_y_i     (s_axis_tdata[63:32]),
    .pt_z_i     (s_axis_tdata[95:64]),
    .cfg_i      (cfg),
    .mw_i       (mw_q),
    .mh_i       (mh_q),
    .out_valid_o(out_valid),
    .value_o    (value),
    .gx_o       (gx),
    .gy_o       (gy),
    .gz_o       (gz)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, gz, gy, gx, value};

endmodule
`default_nettype wire

// ----- rtl/core/bps_chk.sv -----
`default_nettype none
`include "brick_pattern_shader_macros.svh"
module bps_chk (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               s_axis_tvalid,
  input wire logic                               s_axis_tready,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready,
  input wire logic [bps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input wire logic                               cfg_valid_i,
  input wire logic                               cfg_ready_i
);

  // Hold a stalled result.
  `BPS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  // Value within one and padding bit clear.
  `BPS_ASSERT(a_value_range, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[16:0] <= 17'h10000 && m_axis_tdata[71] == 1'b0), "result value out of range")
  // A stalled output stalls the whole pipeline, input side included.
  `BPS_ASSERT(a_stall_blocks_in, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready, "input taken while output stalled")
  // A register write starts the recompute, so nothing is taken next cycle.
  `BPS_ASSERT_NEXT(a_cfg_recompute, clk_i, rst_ni, cfg_valid_i && cfg_ready_i, !s_axis_tready && !cfg_ready_i, "no recompute after register write")

endmodule

bind brick_pattern_shader bps_chk u_bps_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_i   (cfg_ready_o)
);
`default_nettype wire
